### hw/rtl/jdc_pkg.sv
// ----------------------------------------------------------------------------
// jdc_pkg: shared types and constants
// Field widths, register indexes, reset values and the structs passed
// between the joystick dead band, button and gesture modules.
// ----------------------------------------------------------------------------
package jdc_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int DEFL_W     = 13;
  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_LOW         = 3'd0,
    CFG_CENTER_HIGH        = 3'd1,
    CFG_HOLD_TIME_MS       = 3'd2,
    CFG_GESTURE_TIMEOUT_MS = 3'd3,
    CFG_FAR_THRESHOLD      = 3'd4,
    CFG_NEAR_THRESHOLD     = 3'd5
  } cfg_idx_t;

  localparam logic [SAMPLE_W-1:0] RST_CENTER_LOW         = 12'd1900;
  localparam logic [SAMPLE_W-1:0] RST_CENTER_HIGH        = 12'd2200;
  localparam logic [MS_W-1:0]     RST_HOLD_TIME_MS       = 16'd800;
  localparam logic [MS_W-1:0]     RST_GESTURE_TIMEOUT_MS = 16'd2500;
  localparam logic [SAMPLE_W-1:0] RST_FAR_THRESHOLD      = 12'd1200;
  localparam logic [SAMPLE_W-1:0] RST_NEAR_THRESHOLD     = 12'd400;

  typedef struct packed {
    logic [SAMPLE_W-1:0] center_low;
    logic [SAMPLE_W-1:0] center_high;
    logic [MS_W-1:0]     hold_time_ms;
    logic [MS_W-1:0]     gesture_timeout_ms;
    logic [SAMPLE_W-1:0] far_threshold;
    logic [SAMPLE_W-1:0] near_threshold;
  } cfg_t;

  // Button events for the poll in flight
  typedef struct packed {
    logic pressed;
    logic press_edge;
    logic click;
    logic hold;
  } btn_evt_t;

  // Gesture progress, one-hot
  typedef enum logic [6:0] {
    GST_S0 = 7'b0000001,
    GST_S1 = 7'b0000010,
    GST_S2 = 7'b0000100,
    GST_S3 = 7'b0001000,
    GST_S4 = 7'b0010000,
    GST_S5 = 7'b0100000,
    GST_S6 = 7'b1000000
  } gst_state_t;

endpackage

### hw/rtl/jdc_in_if.sv
// ----------------------------------------------------------------------------
// jdc_in_if: poll channel
// Valid/ready channel carrying one joystick poll per transfer.
// ----------------------------------------------------------------------------
interface jdc_in_if;
  import jdc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] x_sample;
  logic [SAMPLE_W-1:0] y_sample;
  logic                button_level;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, output x_sample, output y_sample,
                  output button_level, output now_ms, input ready);
  modport sink   (input valid, input x_sample, input y_sample,
                  input button_level, input now_ms, output ready);
endinterface

### hw/rtl/jdc_out_if.sv
// ----------------------------------------------------------------------------
// jdc_out_if: result channel
// Valid/ready channel carrying deflections and button/gesture events.
// ----------------------------------------------------------------------------
interface jdc_out_if;
  import jdc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DEFL_W-1:0] x_deflection;
  logic signed [DEFL_W-1:0] y_deflection;
  logic                     pressed;
  logic                     press_edge;
  logic                     click_event;
  logic                     hold_event;
  logic                     unlock;

  modport source (output valid, output x_deflection, output y_deflection,
                  output pressed, output press_edge, output click_event,
                  output hold_event, output unlock, input ready);
  modport sink   (input valid, input x_deflection, input y_deflection,
                  input pressed, input press_edge, input click_event,
                  input hold_event, input unlock, output ready);
endinterface

### hw/rtl/jdc_deadband.sv
// ----------------------------------------------------------------------------
// jdc_deadband: axis dead band
// Maps a raw sample to a signed deflection, zero inside the centre window.
// ----------------------------------------------------------------------------
module jdc_deadband (
  input  logic [jdc_pkg::SAMPLE_W-1:0]      sample,
  input  logic [jdc_pkg::SAMPLE_W-1:0]      center_low,
  input  logic [jdc_pkg::SAMPLE_W-1:0]      center_high,
  output logic signed [jdc_pkg::DEFL_W-1:0] deflection
);
  import jdc_pkg::*;

  logic [DEFL_W-1:0] s_ext;
  logic [DEFL_W-1:0] lo_ext;
  logic [DEFL_W-1:0] hi_ext;

  assign s_ext  = {1'b0, sample};
  assign lo_ext = {1'b0, center_low};
  assign hi_ext = {1'b0, center_high};

  // Above-window test wins when the window is inverted
  always_comb begin
    if (sample > center_high) begin
      deflection = signed'(s_ext - hi_ext);
    end else if (sample < center_low) begin
      deflection = signed'(s_ext - lo_ext);
    end else begin
      deflection = '0;
    end
  end
endmodule

### hw/rtl/jdc_button.sv
// ----------------------------------------------------------------------------
// jdc_button: press, hold and click tracking
// Derives press edge, one hold per press and a click on a release with no hold.
// ----------------------------------------------------------------------------
module jdc_button (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          button_level,
  input  logic [jdc_pkg::TIME_W-1:0]    now_ms,
  input  logic [jdc_pkg::MS_W-1:0]      hold_time_ms,
  output jdc_pkg::btn_evt_t             evt
);
  import jdc_pkg::*;

  logic              was_pressed_r;
  logic              hold_reported_r;
  logic [TIME_W-1:0] press_start_r;
  logic [TIME_W-1:0] elapsed;
  logic              pressed;

  assign pressed = ~button_level;
  // Wraps modulo 2^32
  assign elapsed = now_ms - press_start_r;

  always_comb begin
    evt.pressed    = pressed;
    evt.press_edge = pressed & ~was_pressed_r;
    evt.hold       = pressed & was_pressed_r & ~hold_reported_r &
                     (elapsed >= {{(TIME_W-MS_W){1'b0}}, hold_time_ms});
    evt.click      = ~pressed & was_pressed_r & ~hold_reported_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r   <= 1'b0;
      hold_reported_r <= 1'b0;
      press_start_r   <= '0;
    end else if (step) begin
      was_pressed_r <= pressed;
      if (evt.press_edge) begin
        press_start_r   <= now_ms;
        hold_reported_r <= 1'b0;
      end else if (evt.hold) begin
        hold_reported_r <= 1'b1;
      end
    end
  end
endmodule

### hw/rtl/jdc_gesture.sv
// ----------------------------------------------------------------------------
// jdc_gesture: unlock gesture recognizer
// Tracks left, centre, right, centre, left, centre, click on X deflection.
// ----------------------------------------------------------------------------
module jdc_gesture (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic signed [jdc_pkg::DEFL_W-1:0] x_deflection,
  input  logic [jdc_pkg::TIME_W-1:0]        now_ms,
  input  logic                              click,
  input  jdc_pkg::cfg_t                     cfg,
  output logic                              unlock
);
  import jdc_pkg::*;

  localparam int CMP_W = DEFL_W + 1;

  gst_state_t               state_r;
  gst_state_t               state_cur;
  gst_state_t               state_nxt;
  logic [TIME_W-1:0]        last_r;
  logic [TIME_W-1:0]        idle_time;
  logic                     timed_out;
  logic                     advance;
  logic signed [CMP_W-1:0]  dx;
  logic signed [CMP_W-1:0]  far_v;
  logic signed [CMP_W-1:0]  near_v;
  logic                     far_left;
  logic                     far_right;
  logic                     centred;

  assign dx     = CMP_W'(x_deflection);
  assign far_v  = signed'({2'b00, cfg.far_threshold});
  assign near_v = signed'({2'b00, cfg.near_threshold});

  assign far_left  = dx < -far_v;
  assign far_right = dx > far_v;
  assign centred   = (dx > -near_v) && (dx < near_v);

  // Drop to the first stage on inactivity before testing this poll
  assign idle_time = now_ms - last_r;
  assign timed_out = (state_r != GST_S0) &&
                     (idle_time > {{(TIME_W-MS_W){1'b0}}, cfg.gesture_timeout_ms});
  assign state_cur = timed_out ? GST_S0 : state_r;

  always_comb begin
    state_nxt = state_cur;
    advance   = 1'b0;
    unlock    = 1'b0;
    unique case (state_cur)
      GST_S0: if (far_left)  begin state_nxt = GST_S1; advance = 1'b1; end
      GST_S1: if (centred)   begin state_nxt = GST_S2; advance = 1'b1; end
      GST_S2: if (far_right) begin state_nxt = GST_S3; advance = 1'b1; end
      GST_S3: if (centred)   begin state_nxt = GST_S4; advance = 1'b1; end
      GST_S4: if (far_left)  begin state_nxt = GST_S5; advance = 1'b1; end
      GST_S5: if (centred)   begin state_nxt = GST_S6; advance = 1'b1; end
      GST_S6: if (click)     begin state_nxt = GST_S0; unlock  = 1'b1; end
      default: state_nxt = GST_S0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GST_S0;
      last_r  <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      if (advance) begin
        last_r <= now_ms;
      end
    end
  end
endmodule

### hw/rtl/joystick_deadband_click_hold_gesture.sv
// ----------------------------------------------------------------------------
// joystick_deadband_click_hold_gesture: joystick poll processor
// Dead band, click/hold button events and an unlock gesture per poll.
// ----------------------------------------------------------------------------
// One poll per clock while out_if takes every result: a transfer on in_if
// can then happen every cycle, and each poll yields exactly one result on
// out_if through the input register, then the result register. The button
// and gesture state update in the cycle a poll moves from the input register
// to the result register, so consecutive polls chain with no bubble. The result
// register frees up in the cycle its result is taken, so in_if stays ready
// while a result waits, until both registers hold data. Write configuration
// through cfg_we/cfg_index/cfg_wdata only while no poll is in flight; indexes
// beyond the register list are ignored and wide values are truncated to the
// register width. Timestamps wrap modulo 2^32.
// ----------------------------------------------------------------------------
module joystick_deadband_click_hold_gesture (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [jdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  jdc_in_if.sink                          in_if,
  jdc_out_if.source                       out_if
);
  import jdc_pkg::*;

  // Configuration registers
  cfg_t cfg_r;

  // Input register
  logic                in_valid_r;
  logic [SAMPLE_W-1:0] x_r;
  logic [SAMPLE_W-1:0] y_r;
  logic                btn_r;
  logic [TIME_W-1:0]   now_r;

  // Result register
  logic                     out_valid_r;
  logic signed [DEFL_W-1:0] xd_r;
  logic signed [DEFL_W-1:0] yd_r;
  btn_evt_t                 evt_r;
  logic                     unlock_r;

  logic                     step;
  logic                     in_xfer;
  logic signed [DEFL_W-1:0] xd;
  logic signed [DEFL_W-1:0] yd;
  btn_evt_t                 evt;
  logic                     unlock;

  // Advance the input register into the result register when it is free
  assign step         = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !in_valid_r || step;
  assign in_xfer      = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_low         <= RST_CENTER_LOW;
      cfg_r.center_high        <= RST_CENTER_HIGH;
      cfg_r.hold_time_ms       <= RST_HOLD_TIME_MS;
      cfg_r.gesture_timeout_ms <= RST_GESTURE_TIMEOUT_MS;
      cfg_r.far_threshold      <= RST_FAR_THRESHOLD;
      cfg_r.near_threshold     <= RST_NEAR_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER_LOW:         cfg_r.center_low         <= cfg_wdata[SAMPLE_W-1:0];
        CFG_CENTER_HIGH:        cfg_r.center_high        <= cfg_wdata[SAMPLE_W-1:0];
        CFG_HOLD_TIME_MS:       cfg_r.hold_time_ms       <= cfg_wdata[MS_W-1:0];
        CFG_GESTURE_TIMEOUT_MS: cfg_r.gesture_timeout_ms <= cfg_wdata[MS_W-1:0];
        CFG_FAR_THRESHOLD:      cfg_r.far_threshold      <= cfg_wdata[SAMPLE_W-1:0];
        CFG_NEAR_THRESHOLD:     cfg_r.near_threshold     <= cfg_wdata[SAMPLE_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Input register: hold until the poll moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r   <= in_if.x_sample;
      y_r   <= in_if.y_sample;
      btn_r <= in_if.button_level;
      now_r <= in_if.now_ms;
    end
  end

  jdc_deadband u_db_x (
    .sample      (x_r),
    .center_low  (cfg_r.center_low),
    .center_high (cfg_r.center_high),
    .deflection  (xd)
  );

  jdc_deadband u_db_y (
    .sample      (y_r),
    .center_low  (cfg_r.center_low),
    .center_high (cfg_r.center_high),
    .deflection  (yd)
  );

  jdc_button u_button (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .button_level (btn_r),
    .now_ms       (now_r),
    .hold_time_ms (cfg_r.hold_time_ms),
    .evt          (evt)
  );

  // The gesture sees only the click of the same poll
  jdc_gesture u_gesture (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .x_deflection (xd),
    .now_ms       (now_r),
    .click        (evt.click),
    .cfg          (cfg_r),
    .unlock       (unlock)
  );

  // Result register: load on step, clear once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      xd_r     <= xd;
      yd_r     <= yd;
      evt_r    <= evt;
      unlock_r <= unlock;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.x_deflection = xd_r;
  assign out_if.y_deflection = yd_r;
  assign out_if.pressed      = evt_r.pressed;
  assign out_if.press_edge   = evt_r.press_edge;
  assign out_if.click_event  = evt_r.click;
  assign out_if.hold_event   = evt_r.hold;
  assign out_if.unlock       = unlock_r;

`ifndef SYNTHESIS
  // A poll leaving the input register always lands in the result register
  a_step_loads: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("result register not loaded after step");

  // An accepted poll is held in the input register next cycle
  a_xfer_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_valid_r)
    else $error("accepted poll lost");

  // Unlock only comes with the click of the same poll
  a_unlock_click: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && unlock_r |-> evt_r.click)
    else $error("unlock without click");

  // Click and hold never share a poll
  a_click_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(evt_r.click && evt_r.hold))
    else $error("click and hold together");

  // A press edge or hold implies the button is down
  a_edge_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (evt_r.press_edge || evt_r.hold) |-> evt_r.pressed)
    else $error("press event while released");
`endif

endmodule

### sim/joystick_deadband_click_hold_gesture_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_deadband_click_hold_gesture_tb: poll-by-poll self-checking bench
// Drives joystick polls through the valid/ready channel and checks each
// result against a cycle-free predictor of dead band, button events and the
// unlock gesture. Configuration changes between traffic phases, including
// the register extremes.
// ----------------------------------------------------------------------------
module joystick_deadband_click_hold_gesture_tb;
  import jdc_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 8;
  localparam int LATENCY         = 2;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int IDLE_PCT        = 7;
  localparam int CALM_FIRST      = 550;   // no idling on either side in this window
  localparam int CALM_LAST       = 750;
  localparam int HOLDOFF_CYCLES  = 64;
  localparam int PRINT_LIMIT     = 40;

  // One poll as it goes into the block
  typedef struct packed {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic                button;
    logic [TIME_W-1:0]   now;
  } joy_poll_t;

  // One result as it leaves the block
  typedef struct packed {
    logic [DEFL_W-1:0] x_defl;
    logic [DEFL_W-1:0] y_defl;
    logic              pressed;
    logic              press_edge;
    logic              click;
    logic              hold;
    logic              unlock;
  } joy_result_t;

  // Target zones for the X stick when building gesture runs
  typedef enum int {
    ZONE_FAR_LEFT,
    ZONE_CENTRE,
    ZONE_FAR_RIGHT,
    ZONE_ANY
  } stick_zone_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks button and gesture state, predicts one result per
  // transfer, and compares each result the block hands back.
  // --------------------------------------------------------------------------
  class joy_scoreboard;
    cfg_t          regs;
    logic          btn_down;
    logic [31:0]   press_t0;
    logic          hold_sent;
    gst_state_t    stage;
    logic [31:0]   stage_t;
    joy_result_t   expected_q[$];
    int            errors;
    int            polls;
    int            results;
    int            clicks;
    int            holds;
    int            unlocks;
    int            settings;

    function new();
      regs.center_low         = RST_CENTER_LOW;
      regs.center_high        = RST_CENTER_HIGH;
      regs.hold_time_ms       = RST_HOLD_TIME_MS;
      regs.gesture_timeout_ms = RST_GESTURE_TIMEOUT_MS;
      regs.far_threshold      = RST_FAR_THRESHOLD;
      regs.near_threshold     = RST_NEAR_THRESHOLD;
      btn_down  = 1'b0;
      press_t0  = '0;
      hold_sent = 1'b0;
      stage     = GST_S0;
      stage_t   = '0;
      errors    = 0;
      polls     = 0;
      results   = 0;
      clicks    = 0;
      holds     = 0;
      unlocks   = 0;
      settings  = 1;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_CENTER_LOW:         regs.center_low         = v[SAMPLE_W-1:0];
        CFG_CENTER_HIGH:        regs.center_high        = v[SAMPLE_W-1:0];
        CFG_HOLD_TIME_MS:       regs.hold_time_ms       = v[MS_W-1:0];
        CFG_GESTURE_TIMEOUT_MS: regs.gesture_timeout_ms = v[MS_W-1:0];
        CFG_FAR_THRESHOLD:      regs.far_threshold      = v[SAMPLE_W-1:0];
        CFG_NEAR_THRESHOLD:     regs.near_threshold     = v[SAMPLE_W-1:0];
        default: ;
      endcase
    endfunction

    // Signed distance beyond the centre window; the upper edge wins when the
    // window is inverted
    function int deflect(logic [SAMPLE_W-1:0] s);
      int v;
      int lo;
      int hi;
      v  = int'(s);
      lo = int'(regs.center_low);
      hi = int'(regs.center_high);
      if (v > hi) return v - hi;
      if (v < lo) return v - lo;
      return 0;
    endfunction

    function void note_poll(joy_poll_t p);
      joy_result_t r;
      int          dx;
      int          dy;
      int          far_lim;
      int          near_lim;
      logic        down;
      logic [31:0] elapsed;
      logic [31:0] idle_ms;

      dx       = deflect(p.x);
      dy       = deflect(p.y);
      far_lim  = int'(regs.far_threshold);
      near_lim = int'(regs.near_threshold);
      down     = !p.button;
      r        = '0;
      r.x_defl  = dx[DEFL_W-1:0];
      r.y_defl  = dy[DEFL_W-1:0];
      r.pressed = down;

      // Button: edge restarts the hold timer, hold fires once per press,
      // release clicks only when no hold went out
      elapsed = p.now - press_t0;
      if (down && !btn_down) begin
        r.press_edge = 1'b1;
        press_t0     = p.now;
        hold_sent    = 1'b0;
      end else if (down) begin
        if (!hold_sent && elapsed >= 32'(regs.hold_time_ms)) begin
          r.hold    = 1'b1;
          hold_sent = 1'b1;
        end
      end else if (btn_down) begin
        if (!hold_sent) r.click = 1'b1;
      end
      btn_down = down;

      // Gesture: timeout first, then this poll's transition
      idle_ms = p.now - stage_t;
      if (stage != GST_S0 && idle_ms > 32'(regs.gesture_timeout_ms)) stage = GST_S0;
      case (stage)
        GST_S0: if (dx < -far_lim) begin stage = GST_S1; stage_t = p.now; end
        GST_S1: if (dx > -near_lim && dx < near_lim) begin stage = GST_S2; stage_t = p.now; end
        GST_S2: if (dx > far_lim) begin stage = GST_S3; stage_t = p.now; end
        GST_S3: if (dx > -near_lim && dx < near_lim) begin stage = GST_S4; stage_t = p.now; end
        GST_S4: if (dx < -far_lim) begin stage = GST_S5; stage_t = p.now; end
        GST_S5: if (dx > -near_lim && dx < near_lim) begin stage = GST_S6; stage_t = p.now; end
        GST_S6: if (r.click) begin stage = GST_S0; r.unlock = 1'b1; end
        default: ;
      endcase

      expected_q.push_back(r);
      polls++;
      clicks  += int'(r.click);
      holds   += int'(r.hold);
      unlocks += int'(r.unlock);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task check_result(joy_result_t got);
      joy_result_t want;
      if (expected_q.size() == 0) begin
        report("result arrived with no poll outstanding");
        return;
      end
      want = expected_q.pop_front();
      results++;
      if (got.x_defl !== want.x_defl)
        report($sformatf("result %0d x_deflection got %0d want %0d", results,
                         $signed(got.x_defl), $signed(want.x_defl)));
      if (got.y_defl !== want.y_defl)
        report($sformatf("result %0d y_deflection got %0d want %0d", results,
                         $signed(got.y_defl), $signed(want.y_defl)));
      if (got.pressed !== want.pressed)
        report($sformatf("result %0d pressed got %b want %b", results,
                         got.pressed, want.pressed));
      if (got.press_edge !== want.press_edge)
        report($sformatf("result %0d press_edge got %b want %b", results,
                         got.press_edge, want.press_edge));
      if (got.click !== want.click)
        report($sformatf("result %0d click_event got %b want %b", results,
                         got.click, want.click));
      if (got.hold !== want.hold)
        report($sformatf("result %0d hold_event got %b want %b", results,
                         got.hold, want.hold));
      if (got.unlock !== want.unlock)
        report($sformatf("result %0d unlock got %b want %b", results,
                         got.unlock, want.unlock));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic [TIME_W-1:0]     clock_ms;   // running poll timestamp

  jdc_in_if  poll_if ();
  jdc_out_if res_if ();

  joy_scoreboard sb = new();

  joystick_deadband_click_hold_gesture u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_if     (poll_if),
    .out_if    (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Poll driver. Valid only drops during an idle gap or a settle, so a back-to-back
  // transfer never sees valid lowered and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic post(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                      input logic btn, input logic [TIME_W-1:0] now);
    joy_poll_t p;
    p = '{x: x, y: y, button: btn, now: now};
    // Idle now and then, except inside the calm window
    while (!(sb.polls >= CALM_FIRST && sb.polls < CALM_LAST) &&
           $urandom_range(99) < IDLE_PCT) begin
      poll_if.valid <= 1'b0;
      @(posedge clk);
    end
    poll_if.valid        <= 1'b1;
    poll_if.x_sample     <= p.x;
    poll_if.y_sample     <= p.y;
    poll_if.button_level <= p.button;
    poll_if.now_ms       <= p.now;
    // Hold until the block takes it
    do @(posedge clk); while (!poll_if.ready);
    sb.note_poll(p);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic settle();
    poll_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Write all six registers back to back; 12-bit registers get junk in the
  // upper bits to exercise truncation
  task automatic write_cfg(input cfg_t c);
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] v;
    idx = idx.first();
    do begin
      case (idx)
        CFG_CENTER_LOW:         v = {4'($urandom_range(15)), c.center_low};
        CFG_CENTER_HIGH:        v = {4'($urandom_range(15)), c.center_high};
        CFG_HOLD_TIME_MS:       v = c.hold_time_ms;
        CFG_GESTURE_TIMEOUT_MS: v = c.gesture_timeout_ms;
        CFG_FAR_THRESHOLD:      v = {4'($urandom_range(15)), c.far_threshold};
        CFG_NEAR_THRESHOLD:     v = {4'($urandom_range(15)), c.near_threshold};
        default:                v = '0;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= v;
      @(posedge clk);
      sb.set_reg(idx, v);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
    sb.settings++;
  endtask

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.center_low         = RST_CENTER_LOW;
    c.center_high        = RST_CENTER_HIGH;
    c.hold_time_ms       = RST_HOLD_TIME_MS;
    c.gesture_timeout_ms = RST_GESTURE_TIMEOUT_MS;
    c.far_threshold      = RST_FAR_THRESHOLD;
    c.near_threshold     = RST_NEAR_THRESHOLD;
    return c;
  endfunction

  // Register settings per phase: defaults, plausible random windows, both
  // extremes, a degenerate window, and fully random values
  function automatic cfg_t phase_setting(input int ph);
    cfg_t c;
    int   lo;
    c = default_cfg();
    case (ph)
      1, 4, 5: begin
        lo                   = $urandom_range(1200, 2000);
        c.center_low         = 12'(lo);
        c.center_high        = 12'(lo + $urandom_range(0, 600));
        c.hold_time_ms       = 16'($urandom_range(0, 1200));
        c.gesture_timeout_ms = 16'($urandom_range(300, 4000));
        c.far_threshold      = 12'($urandom_range(200, 1100));
        c.near_threshold     = 12'($urandom_range(20, 600));
      end
      2: c = '{center_low: 12'd0, center_high: 12'd4095, hold_time_ms: 16'd0,
               gesture_timeout_ms: 16'd0, far_threshold: 12'd0, near_threshold: 12'd0};
      3: c = '{center_low: 12'd4095, center_high: 12'd0, hold_time_ms: 16'd65535,
               gesture_timeout_ms: 16'd65535, far_threshold: 12'd4095,
               near_threshold: 12'd4095};
      6: begin
        c.center_low         = 12'd4095;
        c.center_high        = 12'd4095;
        c.hold_time_ms       = 16'($urandom_range(0, 300));
        c.gesture_timeout_ms = 16'($urandom_range(0, 300));
        c.far_threshold      = 12'd0;
        c.near_threshold     = 12'd1;
      end
      7: c = cfg_t'($bits(cfg_t)'({$urandom(), $urandom(), $urandom()}));
      default: ;
    endcase
    return c;
  endfunction

  // Pick an X sample that lands in the wanted zone under the current window;
  // half the tries aim straight into the window to find a centred stick
  function automatic logic [SAMPLE_W-1:0] pick_sample(input stick_zone_t z);
    logic [SAMPLE_W-1:0] s;
    int                  d;
    int                  far_lim;
    int                  near_lim;
    far_lim  = int'(sb.regs.far_threshold);
    near_lim = int'(sb.regs.near_threshold);
    s        = '0;
    for (int t = 0; t < 256; t++) begin
      if (z == ZONE_CENTRE && t[0])
        s = 12'($urandom_range(sb.regs.center_low, sb.regs.center_high));
      else
        s = 12'($urandom_range(4095));
      d = sb.deflect(s);
      case (z)
        ZONE_FAR_LEFT:  if (d < -far_lim) return s;
        ZONE_FAR_RIGHT: if (d > far_lim) return s;
        ZONE_CENTRE:    if (d > -near_lim && d < near_lim) return s;
        default:        return s;
      endcase
    end
    return s;
  endfunction

  // Small time steps that keep a gesture alive, with the odd timeout
  function automatic logic [TIME_W-1:0] gentle_step();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 32'(sb.regs.gesture_timeout_ms) + 1;
    if (r < 7) return 32'(sb.regs.gesture_timeout_ms);
    return $urandom_range(0, 150);
  endfunction

  // Any step: boundaries of hold and timeout, and jumps across the whole range
  function automatic logic [TIME_W-1:0] wild_step();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(0, 100);
    if (r < 65) return 32'(sb.regs.hold_time_ms);
    if (r < 72) return 32'(sb.regs.hold_time_ms) - 1;
    if (r < 80) return 32'(sb.regs.gesture_timeout_ms) + 1;
    if (r < 85) return 32'(sb.regs.gesture_timeout_ms);
    return $urandom();
  endfunction

  // Full unlock sequence with random content; now and then a zone is broken
  // or a step times the gesture out
  task automatic gesture_run();
    stick_zone_t path [6];
    stick_zone_t z;
    int          reps;
    path = '{ZONE_FAR_LEFT, ZONE_CENTRE, ZONE_FAR_RIGHT, ZONE_CENTRE, ZONE_FAR_LEFT,
             ZONE_CENTRE};
    foreach (path[k]) begin
      reps = ($urandom_range(99) < 70) ? 1 : $urandom_range(2, 3);
      repeat (reps) begin
        z = ($urandom_range(99) < 5) ? ZONE_ANY : path[k];
        clock_ms += gentle_step();
        post(pick_sample(z), 12'($urandom_range(4095)), ($urandom_range(99) >= 3),
             clock_ms);
      end
    end
    // Press on a centred stick, maybe linger, then let go for the click
    clock_ms += gentle_step();
    post(pick_sample(ZONE_CENTRE), 12'($urandom_range(4095)), 1'b0, clock_ms);
    repeat (($urandom_range(99) < 20) ? $urandom_range(1, 4) : 0) begin
      clock_ms += gentle_step();
      post(pick_sample(ZONE_ANY), 12'($urandom_range(4095)), 1'b0, clock_ms);
    end
    clock_ms += gentle_step();
    post(pick_sample(ZONE_ANY), 12'($urandom_range(4095)), 1'b1, clock_ms);
  endtask

  // Press of random length, long enough to reach hold some of the time
  task automatic button_run();
    repeat ($urandom_range(1, 25)) begin
      clock_ms += ($urandom_range(99) < 15) ? wild_step() : 32'($urandom_range(0, 120));
      post(12'($urandom_range(4095)), 12'($urandom_range(4095)), 1'b0, clock_ms);
    end
    repeat ($urandom_range(1, 3)) begin
      clock_ms += $urandom_range(0, 120);
      post(12'($urandom_range(4095)), 12'($urandom_range(4095)), 1'b1, clock_ms);
    end
  endtask

  task automatic noise_run();
    repeat ($urandom_range(1, 6)) begin
      clock_ms += wild_step();
      post(12'($urandom_range(4095)), 12'($urandom_range(4095)), 1'($urandom_range(1)),
           clock_ms);
    end
  endtask

  task automatic run_random(input int n);
    int start;
    int r;
    start = sb.polls;
    while (sb.polls - start < n) begin
      r = $urandom_range(99);
      if (r < 55)      gesture_run();
      else if (r < 80) button_run();
      else             noise_run();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed polls, then random phases under changing
  // register settings
  // --------------------------------------------------------------------------
  initial begin : stimulus
    poll_if.valid        <= 1'b0;
    poll_if.x_sample     <= '0;
    poll_if.y_sample     <= '0;
    poll_if.button_level <= 1'b1;
    poll_if.now_ms       <= '0;
    cfg_we               <= 1'b0;
    cfg_index            <= CFG_CENTER_LOW;
    cfg_wdata            <= '0;
    clock_ms              = '0;
    rst_n                <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: sample extremes and window edges while walking the
    // whole unlock gesture, ending in a click on the press poll's release
    post(12'd0,    12'd4095, 1'b1, 32'd0);
    post(12'd4095, 12'd0,    1'b1, 32'd100);
    post(12'd1900, 12'd2200, 1'b1, 32'd200);
    post(12'd2201, 12'd1899, 1'b1, 32'd300);
    post(12'd4095, 12'd2000, 1'b1, 32'd400);
    post(12'd2000, 12'd2000, 1'b1, 32'd500);
    post(12'd0,    12'd2000, 1'b1, 32'd600);
    post(12'd2050, 12'd2000, 1'b0, 32'd700);
    post(12'd2050, 12'd2000, 1'b1, 32'd750);
    // Hold right at the threshold, once per press, and no click after it
    post(12'd2000, 12'd2000, 1'b0, 32'd1000);
    post(12'd2000, 12'd2000, 1'b0, 32'd1799);
    post(12'd2000, 12'd2000, 1'b0, 32'd1800);
    post(12'd2000, 12'd2000, 1'b0, 32'd5000);
    post(12'd2000, 12'd2000, 1'b1, 32'd5100);
    // Gesture timeout: equal to the limit keeps the stage, well past it drops it
    post(12'd0,    12'd2000, 1'b1, 32'd6000);
    post(12'd0,    12'd2000, 1'b1, 32'd8500);
    post(12'd2000, 12'd2000, 1'b1, 32'd11001);
    // Timestamp wrap across a gesture step and a hold
    post(12'd0,    12'd2000, 1'b1, 32'hFFFF_FF00);
    post(12'd2000, 12'd2000, 1'b0, 32'hFFFF_FFF0);
    post(12'd2000, 12'd2000, 1'b0, 32'h0000_0310);
    post(12'd2000, 12'd2000, 1'b1, 32'h0000_0320);

    // Inverted window and a zero hold time
    settle();
    write_cfg('{center_low: 12'd3000, center_high: 12'd1000, hold_time_ms: 16'd0,
                gesture_timeout_ms: 16'd2500, far_threshold: 12'd1200,
                near_threshold: 12'd400});
    post(12'd2000, 12'd500,  1'b0, 32'd50);
    post(12'd1000, 12'd999,  1'b0, 32'd50);
    post(12'd3000, 12'd4095, 1'b1, 32'd60);
    post(12'd500,  12'd1001, 1'b0, 32'd70);
    post(12'd500,  12'd1001, 1'b1, 32'd70);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      write_cfg(phase_setting(ph));
      clock_ms = (ph == 4) ? 32'hFFFF_F800 : $urandom();
      run_random(ITEMS_PER_PHASE);
    end

    settle();
    $display("Checked %0d results from %0d polls across %0d register settings.",
             sb.results, sb.polls, sb.settings);
    $display("Events predicted: %0d clicks, %0d holds, %0d unlocks; %0d mismatches.",
             sb.clicks, sb.holds, sb.unlocks, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result sink: check every transfer, stall at random, and twice hold ready
  // low long enough that the block fills and stops taking polls
  // --------------------------------------------------------------------------
  initial begin : result_sink
    joy_result_t got;
    int          taken;
    int          holdoff;
    bit          calm;
    taken   = 0;
    holdoff = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        got.x_defl     = res_if.x_deflection;
        got.y_defl     = res_if.y_deflection;
        got.pressed    = res_if.pressed;
        got.press_edge = res_if.press_edge;
        got.click      = res_if.click_event;
        got.hold       = res_if.hold_event;
        got.unlock     = res_if.unlock;
        sb.check_result(got);
        taken++;
        if (taken == 300 || taken == 1000) holdoff = HOLDOFF_CYCLES;
      end
      calm = (taken >= CALM_FIRST && taken < CALM_LAST);
      if (holdoff > 0) begin
        holdoff--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Hard stop if the run hangs
  initial begin : watchdog
    #(CLK_PERIOD * 400000);
    $display("Timeout: %0d results still outstanding", sb.pending());
    $display("Verification failed");
    $finish;
  end

endmodule
